/* hdl/tdmd_pkg.sv */
// ----------------------------------------------------------------------------
// tdmd_pkg: shared definitions for the timed dual motor drive
// Widths, motor count, bridge codes, duty scaling constants and the
// per-motor state record used between the channel and the top level.
// ----------------------------------------------------------------------------
package tdmd_pkg;

  // Number of motor channels; motor 0 is shown as left, motor 1 as right.
  localparam int unsigned MOTORS      = 2;
  localparam int unsigned RIGHT_SHOWN = (MOTORS > 1) ? 1 : 0;

  localparam int unsigned SPEED_W = 8;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned MAG_W   = 7;   // limited magnitude 0..100

  localparam logic [MAG_W-1:0]  SPEED_LIMIT     = MAG_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_FULL_RESET = DUTY_W'(170);

  // Divide by 100 as multiply by 5243 and shift right by 19; exact for
  // products below 43690, and magnitude * full-speed duty stays below 25501.
  localparam int unsigned RECIP       = 5243;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned SCALE_W     = DUTY_W + RECIP_W;
  localparam int unsigned PROD_W      = MAG_W + SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(170 * RECIP);

  // Input kind, carried in tuser.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DRIVE = 1'b1;

  // Bridge bits: bit 0 = input one (cw, reverse), bit 1 = input two (ccw, forward).
  localparam logic [1:0] BRIDGE_STOP = 2'b00;
  localparam logic [1:0] BRIDGE_REV  = 2'b01;
  localparam logic [1:0] BRIDGE_FWD  = 2'b10;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [1:0]         bridge;
    logic [TICKS_W-1:0] remaining;
  } chan_state_t;

  localparam int unsigned IN_DATA_W  = 2 * SPEED_W + TICKS_W;
  localparam int unsigned OUT_BITS   = 2 * (DUTY_W + 2) + 2 * TICKS_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

/* hdl/tdmd_cfg.sv */
// ----------------------------------------------------------------------------
// tdmd_cfg: full-speed duty register
// Holds the full-speed duty premultiplied by the reciprocal of 100, so that
// the duty update needs a single multiply.
// ----------------------------------------------------------------------------
module tdmd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               duty_full_we_i,
  input  logic [tdmd_pkg::DUTY_W-1:0]        duty_full_i,
  output logic [tdmd_pkg::SCALE_W-1:0]       scale_o
);

  logic [tdmd_pkg::SCALE_W-1:0] scale_q, scale_d;

  assign scale_d = tdmd_pkg::SCALE_W'(duty_full_i)
                 * tdmd_pkg::SCALE_W'(tdmd_pkg::RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= tdmd_pkg::SCALE_RESET;
    end else if (duty_full_we_i) begin
      scale_q <= scale_d;
    end
  end

  assign scale_o = scale_q;

endmodule

/* hdl/tdmd_channel.sv */
// ----------------------------------------------------------------------------
// tdmd_channel: one motor channel
// Holds duty, bridge bits and tick count for one motor; loads them on a
// drive beat and counts down on a tick beat.
// ----------------------------------------------------------------------------
module tdmd_channel (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                cmd_i,
  input  logic signed [tdmd_pkg::SPEED_W-1:0] speed_i,
  input  logic [tdmd_pkg::TICKS_W-1:0]        ticks_i,
  input  logic [tdmd_pkg::SCALE_W-1:0]        scale_i,
  output tdmd_pkg::chan_state_t               state_o
);

  tdmd_pkg::chan_state_t state_q, state_d;
  logic moving_q, moving_d;

  logic [tdmd_pkg::SPEED_W-1:0] mag_raw;
  logic [tdmd_pkg::MAG_W-1:0]   mag;
  logic [tdmd_pkg::PROD_W-1:0]  prod;
  logic [tdmd_pkg::TICKS_W-1:0] rem_dec;

  // |speed|, with -128 read as 128; limit to 100.
  always_comb begin
    mag_raw = speed_i[tdmd_pkg::SPEED_W-1] ? (~speed_i + 1'b1) : speed_i;
    if (mag_raw > tdmd_pkg::SPEED_W'(tdmd_pkg::SPEED_LIMIT)) begin
      mag = tdmd_pkg::SPEED_LIMIT;
    end else begin
      mag = mag_raw[tdmd_pkg::MAG_W-1:0];
    end
  end

  assign prod    = tdmd_pkg::PROD_W'(mag) * tdmd_pkg::PROD_W'(scale_i);
  assign rem_dec = state_q.remaining - 1'b1;

  always_comb begin
    state_d  = state_q;
    moving_d = moving_q;
    if (step_i) begin
      if (cmd_i == tdmd_pkg::CMD_DRIVE) begin
        state_d.duty      = prod[tdmd_pkg::RECIP_SHIFT +: tdmd_pkg::DUTY_W];
        state_d.remaining = ticks_i;
        moving_d          = (speed_i != '0);
        priority if (speed_i == '0) begin
          state_d.bridge = tdmd_pkg::BRIDGE_STOP;
        end else if (speed_i[tdmd_pkg::SPEED_W-1]) begin
          state_d.bridge = tdmd_pkg::BRIDGE_REV;
        end else begin
          state_d.bridge = tdmd_pkg::BRIDGE_FWD;
        end
      end else if (state_q.remaining != '0) begin
        state_d.remaining = rem_dec;
        // Timed run over: stop the bridge and drop the duty.
        if (moving_q && (rem_dec == '0)) begin
          state_d.duty   = '0;
          state_d.bridge = tdmd_pkg::BRIDGE_STOP;
          moving_d       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '0;
      moving_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      moving_q <= moving_d;
    end
  end

  assign state_o = state_q;

endmodule

/* hdl/timed_dual_motor_drive.sv */
// ----------------------------------------------------------------------------
// timed_dual_motor_drive: two H-bridge channels with timed runs
// Takes drive and tick beats, keeps per-motor duty, bridge bits and tick
// counts, and returns one status beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat is either a drive command (tuser high) or a time tick
// (tuser low), and every input beat yields exactly one output beat showing
// motor 0 (left) and motor 1 (right) after the update. A drive command sets
// each motor's duty to min(|speed|,100) * duty_full / 100 (truncated), its
// bridge to forward (ccw) for positive, reverse (cw) for negative, stop for
// zero, and loads run_ticks into both counts; run_ticks of 0 means run with no
// timeout. A tick decrements every nonzero count, and a moving motor whose
// count hits zero stops with duty 0. The path is two registers deep: an
// input register, then the channel state, which doubles as the output
// register. One beat per cycle is sustained while m_axis_tready stays
// high; the limiting path is the 7 x 21 bit duty multiply in each channel.
// The full-speed duty is written through duty_full_we_i while no beat is
// in flight; a new value takes effect at the next drive command.
// ----------------------------------------------------------------------------
module timed_dual_motor_drive (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: left_speed[7:0], right_speed[15:8], run_ticks[31:16]
  input  logic [tdmd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: cmd (0 = tick, 1 = drive)
  input  logic                                 s_axis_tuser,
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: duty_left[7:0], cw_left[8], ccw_left[9], duty_right[17:10],
  //        cw_right[18], ccw_right[19], left_remaining[35:20],
  //        right_remaining[51:36], zero fill [55:52]
  output logic [tdmd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration
  input  logic                                 duty_full_we_i,
  input  logic [tdmd_pkg::DUTY_W-1:0]          duty_full_i
);

  // Input register
  logic                                 in_valid_q, in_valid_d;
  logic                                 cmd_q;
  logic [tdmd_pkg::SPEED_W-1:0]         speed_l_q, speed_r_q;
  logic [tdmd_pkg::TICKS_W-1:0]         ticks_q;
  logic                                 out_valid_q, out_valid_d;
  logic                                 advance;
  logic                                 in_take;

  logic [tdmd_pkg::SCALE_W-1:0]         scale;
  tdmd_pkg::chan_state_t                chan_state [tdmd_pkg::MOTORS];
  tdmd_pkg::chan_state_t                left_st, right_st;

  // Advance the held beat into the channels when the output slot is free
  // or being emptied in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold until the next accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q     <= s_axis_tuser;
      speed_l_q <= s_axis_tdata[0 +: tdmd_pkg::SPEED_W];
      speed_r_q <= s_axis_tdata[tdmd_pkg::SPEED_W +: tdmd_pkg::SPEED_W];
      ticks_q   <= s_axis_tdata[2*tdmd_pkg::SPEED_W +: tdmd_pkg::TICKS_W];
    end
  end

  tdmd_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .duty_full_we_i (duty_full_we_i),
    .duty_full_i    (duty_full_i),
    .scale_o        (scale)
  );

  // Motor 0 takes the left speed, all others the right speed.
  for (genvar m = 0; m < tdmd_pkg::MOTORS; m++) begin : g_chan
    tdmd_channel u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (advance),
      .cmd_i   (cmd_q),
      .speed_i ((m == 0) ? speed_l_q : speed_r_q),
      .ticks_i (ticks_q),
      .scale_i (scale),
      .state_o (chan_state[m])
    );
  end

  assign left_st  = chan_state[0];
  assign right_st = chan_state[tdmd_pkg::RIGHT_SHOWN];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdmd_pkg::OUT_DATA_W'({
                           right_st.remaining,
                           left_st.remaining,
                           right_st.bridge[1], right_st.bridge[0], right_st.duty,
                           left_st.bridge[1],  left_st.bridge[0],  left_st.duty
                         });

endmodule
